// ===== hdl/u8dw_pkg.sv =====
// u8dw_pkg: shared types, constants and decode functions for the utf-8 display width decoder
// no dependencies
`timescale 1ns / 1ps
package u8dw_pkg;

	localparam int TAB_STOP_DEF     = 4;
	localparam int COUNTER_BITS_DEF = 16;
	localparam int QUEUE_DEPTH      = 2;
	localparam int NUM_RANGES       = 21;

	localparam logic [20:0] CP_TAB = 21'h09;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
		logic            eob;
	} job_t;

	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  nb;
	} dec_t;

	typedef struct packed {
		logic [20:0] lo;
		logic [20:0] hi;
		logic [1:0]  w;
	} wrange_t;

	localparam wrange_t WTAB [NUM_RANGES] = '{
		'{21'h00300, 21'h0036F, 2'd0}, '{21'h0093C, 21'h0094D, 2'd0},
		'{21'h00951, 21'h00957, 2'd0}, '{21'h01100, 21'h011FF, 2'd2},
		'{21'h02E80, 21'h02EFF, 2'd2}, '{21'h02F00, 21'h02FDF, 2'd2},
		'{21'h03000, 21'h0318F, 2'd2}, '{21'h031F0, 21'h031FF, 2'd2},
		'{21'h03400, 21'h04DBF, 2'd2}, '{21'h04E00, 21'h09FFF, 2'd2},
		'{21'h0A000, 21'h0A4CF, 2'd2}, '{21'h0AC00, 21'h0D7AF, 2'd2},
		'{21'h0D800, 21'h0DFFF, 2'd0}, '{21'h0F900, 21'h0FAFF, 2'd2},
		'{21'h0FE00, 21'h0FE0F, 2'd0}, '{21'h0FE10, 21'h0FE1F, 2'd2},
		'{21'h0FE30, 21'h0FE4F, 2'd2}, '{21'h0FF00, 21'h0FFEF, 2'd2},
		'{21'h1F000, 21'h1F1FF, 2'd2}, '{21'h1F300, 21'h1F77F, 2'd2},
		'{21'h1F900, 21'h1F9FF, 2'd2}
	};

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] n;
		if (c < 8'h80) n = 3'd1;
		else if ((c & 8'hE0) == 8'hC0) n = 3'd2;
		else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
		else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
		else n = 3'd1;
		return n;
	endfunction

	function automatic dec_t decode(input logic [3:0][7:0] b, input logic [1:0] pos,
			input logic [2:0] len);
		dec_t       d;
		logic [7:0] c;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] n;
		logic [3:0] endp;
		c    = b[pos];
		b1   = b[pos + 2'd1];
		b2   = b[pos + 2'd2];
		b3   = b[pos + 2'd3];
		n    = lead_len(c);
		endp = {2'b00, pos} + {1'b0, n} - 4'd1;
		d.nb = 3'd1;
		d.cp = '0;
		if (c < 8'h80) begin
			d.cp = {13'd0, c};
		end else if (n >= 3'd2 && endp < {1'b0, len}) begin
			d.nb = n;
			case (n)
				3'd2: d.cp = {10'd0, c[4:0], b1[5:0]};
				3'd3: d.cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
				default: d.cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
			endcase
		end
		return d;
	endfunction

	function automatic logic [1:0] table_width(input logic [20:0] cp);
		logic [1:0] w;
		w = 2'd1;
		for (int i = NUM_RANGES - 1; i >= 0; i--) begin
			if (cp >= WTAB[i].lo && cp <= WTAB[i].hi) w = WTAB[i].w;
		end
		return w;
	endfunction

endpackage

// ===== hdl/u8dw_front.sv =====
// u8dw_front: takes input bytes, gathers sequences by lead length, issues decode jobs
// depends on u8dw_pkg
`timescale 1ns / 1ps
module u8dw_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    data_byte,
	input  logic          end_of_buffer,
	output u8dw_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_full
);
	import u8dw_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic       accept;
	logic [2:0] n;
	logic [2:0] need;

	assign full   = job_full;
	assign accept = push && !full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < held_cnt_q) job.bytes[i] = held_q[i];
			else if (2'(i) == held_cnt_q) job.bytes[i] = data_byte;
			else job.bytes[i] = 8'h00;
		end
		job.bytes[3] = (held_cnt_q == 2'd3) ? data_byte : 8'h00;
		n            = {1'b0, held_cnt_q} + 3'd1;
		need         = lead_len(job.bytes[0]);
		job.len      = n;
		job.eob      = end_of_buffer;
		job_valid    = accept && (end_of_buffer || n >= need);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (job_valid) held_cnt_q <= 2'd0;
			else held_cnt_q <= held_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !job_valid) held_q[held_cnt_q] <= data_byte;
	end

endmodule

// ===== hdl/u8dw_queue.sv =====
// u8dw_queue: short job queue between front and back
// depends on u8dw_pkg
`timescale 1ns / 1ps
module u8dw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  u8dw_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output u8dw_pkg::job_t rdata,
	output logic          valid
);
	import u8dw_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = cnt_q == CW'(QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== hdl/u8dw_back.sv =====
// u8dw_back: decodes jobs one char per beat unless stalled, tracks offset, column, tab phase
// depends on u8dw_pkg
`timescale 1ns / 1ps
module u8dw_back #(
	parameter int TAB_STOP     = u8dw_pkg::TAB_STOP_DEF,
	parameter int COUNTER_BITS = u8dw_pkg::COUNTER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  u8dw_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_pop,
	output logic          empty,
	input  logic          pop,
	output logic [20:0]   code_point,
	output logic          invalid_char,
	output logic [2:0]    seq_bytes,
	output logic [4:0]    char_width,
	output logic [15:0]   byte_offset,
	output logic [15:0]   column_before,
	output logic          last_of_run
);
	import u8dw_pkg::*;

	localparam int CB = COUNTER_BITS;
	localparam int PW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam longint unsigned CMAX = (64'd1 << COUNTER_BITS) - 64'd1;
	localparam logic [PW-1:0] PMAX = PW'(CMAX % TAB_STOP);
	localparam logic [CB-1:0] CSAT = '1;

	logic [1:0]    pos_q;
	logic [CB-1:0] off_q;
	logic [CB-1:0] col_q;
	logic [PW-1:0] ph_q;
	logic          out_v_q;

	dec_t          d;
	logic [1:0]    tw;
	logic          inv;
	logic [4:0]    w;
	logic          fire;
	logic          done;
	logic [CB:0]   off_sum;
	logic [CB:0]   col_sum;
	logic [CB-1:0] off_nx;
	logic [CB-1:0] col_nx;
	logic [PW+1:0] ph_t;
	logic [PW-1:0] ph_nx;

	always_comb begin
		d    = decode(job.bytes, pos_q, job.len);
		tw   = table_width(d.cp);
		inv  = d.cp == '0 && d.nb == 3'd1;
		if (inv) w = 5'd1;
		else if (d.cp == CP_TAB) w = 5'(TAB_STOP) - 5'(ph_q);
		else w = {3'b000, tw};
		fire    = job_valid && (!out_v_q || pop);
		done    = ({2'b00, pos_q} + {1'b0, d.nb}) >= {1'b0, job.len};
		job_pop = fire && done;
		off_sum = {1'b0, off_q} + (CB + 1)'(d.nb);
		col_sum = {1'b0, col_q} + (CB + 1)'(tw);
		off_nx  = (off_sum >= {1'b0, CSAT}) ? CSAT : off_sum[CB-1:0];
		col_nx  = (col_sum >= {1'b0, CSAT}) ? CSAT : col_sum[CB-1:0];
		ph_t    = (PW + 2)'(ph_q) + (PW + 2)'(tw);
		if (ph_t >= (PW + 2)'(TAB_STOP)) ph_t = ph_t - (PW + 2)'(TAB_STOP);
		if (ph_t >= (PW + 2)'(TAB_STOP)) ph_t = ph_t - (PW + 2)'(TAB_STOP);
		ph_nx   = (col_sum >= {1'b0, CSAT}) ? PMAX : ph_t[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			off_q   <= '0;
			col_q   <= '0;
			ph_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			if (fire) begin
				pos_q <= done ? 2'd0 : pos_q + d.nb[1:0];
				if (done && job.eob) begin
					off_q <= '0;
					col_q <= '0;
					ph_q  <= '0;
				end else begin
					off_q <= off_nx;
					col_q <= col_nx;
					ph_q  <= ph_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_point    <= d.cp;
			invalid_char  <= inv;
			seq_bytes     <= d.nb;
			char_width    <= w;
			byte_offset   <= 16'(off_q);
			column_before <= 16'(col_q);
			last_of_run   <= done;
		end
	end

	assign empty = !out_v_q;

endmodule

// ===== hdl/utf8_display_width_decoder_top.sv =====
// utf-8 display width decoder: one byte per beat in unless full, one result per character out
// a byte completing a character is queued as a job, then decoded into the result register
// throughput: 1 byte per cycle unless full; a cut-off sequence at end of buffer yields up to
// 3 results, one per popped cycle, from the back decoder while the job queue absorbs input
// reset: asynchronous, clears held count, counters, tab phase, queue and output valid
// depends on u8dw_pkg, u8dw_front, u8dw_queue, u8dw_back
`timescale 1ns / 1ps
module utf8_display_width_decoder_top #(
	parameter int TAB_STOP     = u8dw_pkg::TAB_STOP_DEF,
	parameter int COUNTER_BITS = u8dw_pkg::COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] code_point,
	output logic        invalid_char,
	output logic [2:0]  seq_bytes,
	output logic [4:0]  char_width,
	output logic [15:0] byte_offset,
	output logic [15:0] column_before,
	output logic        last_of_run
);
	import u8dw_pkg::*;

	job_t f_job;
	logic f_valid;
	logic q_full;
	job_t q_job;
	logic q_valid;
	logic q_pop;

	u8dw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.job          (f_job),
		.job_valid    (f_valid),
		.job_full     (q_full)
	);

	u8dw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (f_valid),
		.wdata (f_job),
		.full  (q_full),
		.rd    (q_pop),
		.rdata (q_job),
		.valid (q_valid)
	);

	u8dw_back #(
		.TAB_STOP    (TAB_STOP),
		.COUNTER_BITS(COUNTER_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (q_job),
		.job_valid    (q_valid),
		.job_pop      (q_pop),
		.empty        (empty),
		.pop          (pop),
		.code_point   (code_point),
		.invalid_char (invalid_char),
		.seq_bytes    (seq_bytes),
		.char_width   (char_width),
		.byte_offset  (byte_offset),
		.column_before(column_before),
		.last_of_run  (last_of_run)
	);

	a_inv_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && invalid_char |-> code_point == 21'd0 && seq_bytes == 3'd1)
		else $error("invalid character with nonzero code or length");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> char_width <= 5'd16 && seq_bytes >= 3'd1 && seq_bytes <= 3'd4)
		else $error("result width or length out of range");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back decoder retired a job from an empty queue");

endmodule
